// File: rtl/c_escape_sequence_decoder_top_assert.svh
// Assertion macros for the C escape sequence decoder.
// Used by c_escape_sequence_decoder_top; needs clk and rst_n in scope.
`ifndef C_ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH
`define C_ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CESD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CESD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cesd_pkg.sv
// Shared types and constants for the C escape sequence decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cesd_pkg;

    localparam int CHAR_W      = 21;
    localparam int CHAR_BYTES_W = 24;
    localparam int CP_W        = 32;
    localparam int QUEUE_DEPTH = 4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 21'h5C;
    localparam logic [CHAR_W-1:0] CH_SQUOTE    = 21'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE    = 21'h22;
    localparam logic [CHAR_W-1:0] CH_QMARK     = 21'h3F;
    localparam logic [CHAR_W-1:0] CH_A         = 21'h61;
    localparam logic [CHAR_W-1:0] CH_B         = 21'h62;
    localparam logic [CHAR_W-1:0] CH_E         = 21'h65;
    localparam logic [CHAR_W-1:0] CH_F         = 21'h66;
    localparam logic [CHAR_W-1:0] CH_N         = 21'h6E;
    localparam logic [CHAR_W-1:0] CH_R         = 21'h72;
    localparam logic [CHAR_W-1:0] CH_T         = 21'h74;
    localparam logic [CHAR_W-1:0] CH_V         = 21'h76;
    localparam logic [CHAR_W-1:0] CH_X         = 21'h78;
    localparam logic [CHAR_W-1:0] CH_U_LOW     = 21'h75;
    localparam logic [CHAR_W-1:0] CH_U_UP      = 21'h55;

    // control codes produced by the letter escapes
    localparam logic [CP_W-1:0] CODE_BEL = 32'h07;
    localparam logic [CP_W-1:0] CODE_BS  = 32'h08;
    localparam logic [CP_W-1:0] CODE_ESC = 32'h1B;
    localparam logic [CP_W-1:0] CODE_FF  = 32'h0C;
    localparam logic [CP_W-1:0] CODE_LF  = 32'h0A;
    localparam logic [CP_W-1:0] CODE_CR  = 32'h0D;
    localparam logic [CP_W-1:0] CODE_HT  = 32'h09;
    localparam logic [CP_W-1:0] CODE_VT  = 32'h0B;

    // range limits
    localparam logic [CP_W-1:0] OCTAL_MAX     = 32'hFF;
    localparam logic [CP_W-1:0] SURR_LOW      = 32'hD800;
    localparam logic [CP_W-1:0] SURR_END      = 32'hE000;
    localparam logic [CP_W-1:0] BMP_MAX       = 32'hFFFF;

    // one queue entry: one or two decoded code points of a single input word
    typedef struct packed {
        logic [1:0]      count;
        logic [CP_W-1:0] v0;
        logic [CP_W-1:0] v1;
    } entry_t;

    // queue status seen by the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: rtl/c_escape_sequence_decoder_top.sv
// Top level of the C escape sequence decoder.
// Depends on cesd_pkg, cesd_front, cesd_queue, cesd_back and the assert header.
`timescale 1ns / 1ps
//
// Usage:
//   Input stream s_*: one character code per word in s_tdata, s_tlast on the
//   final character of a string. Output stream m_*: one decoded code point
//   per word in m_tdata; m_tlast marks the final word produced by an input
//   word. An input word yields zero, one or two output words.
//   Throughput: one input word per cycle while the queue is not full and each
//   gives at most one output word; the output side delivers one word per cycle
//   while m_tready is high, so a word that yields two output words holds it
//   for both. An accepted input word is written into the queue, then loaded into
//   the output register once that register is free and earlier entries have left.
//   The decoder state advances once per accepted word; the queue of
//   QUEUE_DEPTH entries lets the front keep accepting while the receiver
//   stalls, and s_tready drops only once the queue is full.
//   Reset: asynchronous, active low; clears decoder state, queue and output
//   valid. s_tready is low while reset is held and high from its release.

module c_escape_sequence_decoder_top #(
    parameter int QUEUE_DEPTH = cesd_pkg::QUEUE_DEPTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cesd_pkg::CHAR_BYTES_W-1:0]   s_tdata,   // [20:0] char_code, rest zero
    input  logic                                s_tlast,   // last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cesd_pkg::CP_W-1:0]           m_tdata,   // [31:0] code_point
    output logic                                m_tlast    // end_of_run
);

    logic                  q_push;
    logic                  q_pop;
    cesd_pkg::entry_t      q_in;
    cesd_pkg::entry_t      q_head;
    cesd_pkg::queue_stat_t q_stat;

    // decoder front end
    cesd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .char_code  (s_tdata[cesd_pkg::CHAR_W-1:0]),
        .last       (s_tlast),
        .q_stat     (q_stat),
        .push       (q_push),
        .push_entry (q_in)
    );

    // entry queue
    cesd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    // output back end
    cesd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .code_point (m_tdata),
        .end_of_run (m_tlast)
    );

    // checks
    `include "c_escape_sequence_decoder_top_assert.svh"

    `CESD_ASSERT_NOW(a_push_not_full, q_push, !q_stat.full, "push into a full queue")
    `CESD_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty, "pop from an empty queue")
    `CESD_ASSERT_NOW(a_entry_nonzero, q_push, (q_in.count == 2'd1) || (q_in.count == 2'd2),
        "queue entry without a code point")
    `CESD_ASSERT_NEXT(a_pop_loads_last, q_pop, m_tvalid && m_tlast,
        "entry retired without its final word")

endmodule

// File: rtl/cesd_front.sv
// Front end: accepts input words, runs the escape decoder state and
// produces one queue entry per word that yields output. Uses cesd_pkg.
`timescale 1ns / 1ps

module cesd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cesd_pkg::CHAR_W-1:0]   char_code,
    input  logic                          last,
    input  cesd_pkg::queue_stat_t         q_stat,
    output logic                          push,
    output cesd_pkg::entry_t              push_entry
);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_OCTAL,
        MODE_HEX,
        MODE_UNI4,
        MODE_UNI8
    } mode_t;

    mode_t                       mode_reg, mode_next;
    logic [cesd_pkg::CP_W-1:0]   acc_reg, acc_next;
    logic [3:0]                  cnt_reg, cnt_next;
    logic                        inv_reg, inv_next;
    cesd_pkg::entry_t            ent;
    logic                        accept;
    logic                        is_hex;
    logic [3:0]                  hex_val;
    logic                        is_oct;
    logic [3:0]                  need;

    // append one code point to the entry being built
    function automatic cesd_pkg::entry_t add_cp(cesd_pkg::entry_t e,
                                                logic [cesd_pkg::CP_W-1:0] v);
        cesd_pkg::entry_t r;
        r = e;
        if (e.count == 2'd0)
        begin
            r.v0    = v;
            r.count = 2'd1;
        end
        else if (e.count == 2'd1)
        begin
            r.v1    = v;
            r.count = 2'd2;
        end
        return r;
    endfunction

    function automatic logic hex_ok(logic [cesd_pkg::CP_W-1:0] v, logic [3:0] n);
        return (n != 4'd0) && ((v < cesd_pkg::SURR_LOW) ||
               ((v >= cesd_pkg::SURR_END) && (v <= cesd_pkg::BMP_MAX)));
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = rst_n && !q_stat.full;

    // digit classification; the full 21-bit compare keeps wide codes out
    always_comb
    begin
        is_oct  = (char_code >= 21'h30) && (char_code <= 21'h37);
        is_hex  = 1'b0;
        hex_val = char_code[3:0];
        if ((char_code >= 21'h30) && (char_code <= 21'h39))
        begin
            is_hex = 1'b1;
        end
        else if (((char_code >= 21'h61) && (char_code <= 21'h66)) ||
                 ((char_code >= 21'h41) && (char_code <= 21'h46)))
        begin
            is_hex  = 1'b1;
            hex_val = char_code[3:0] + 4'd9;
        end
        need = (mode_reg == MODE_UNI4) ? 4'd4 : 4'd8;
    end

    // decode step for one word
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        inv_next  = inv_reg;
        ent       = '0;

        unique case (mode_reg)
            MODE_ESCAPE:
            begin
                mode_next = MODE_NORMAL;
                acc_next  = '0;
                cnt_next  = '0;
                inv_next  = 1'b0;
                unique case (char_code)
                    cesd_pkg::CH_A:         ent = add_cp(ent, cesd_pkg::CODE_BEL);
                    cesd_pkg::CH_B:         ent = add_cp(ent, cesd_pkg::CODE_BS);
                    cesd_pkg::CH_E:         ent = add_cp(ent, cesd_pkg::CODE_ESC);
                    cesd_pkg::CH_F:         ent = add_cp(ent, cesd_pkg::CODE_FF);
                    cesd_pkg::CH_N:         ent = add_cp(ent, cesd_pkg::CODE_LF);
                    cesd_pkg::CH_R:         ent = add_cp(ent, cesd_pkg::CODE_CR);
                    cesd_pkg::CH_T:         ent = add_cp(ent, cesd_pkg::CODE_HT);
                    cesd_pkg::CH_V:         ent = add_cp(ent, cesd_pkg::CODE_VT);
                    cesd_pkg::CH_BACKSLASH,
                    cesd_pkg::CH_SQUOTE,
                    cesd_pkg::CH_DQUOTE,
                    cesd_pkg::CH_QMARK:     ent = add_cp(ent, 32'(char_code));
                    cesd_pkg::CH_X:         mode_next = MODE_HEX;
                    cesd_pkg::CH_U_LOW:     mode_next = MODE_UNI4;
                    cesd_pkg::CH_U_UP:      mode_next = MODE_UNI8;
                    default:
                    begin
                        // first octal digit; unknown escapes are dropped
                        if (is_oct)
                        begin
                            mode_next = MODE_OCTAL;
                            acc_next  = {29'd0, char_code[2:0]};
                            cnt_next  = 4'd1;
                        end
                    end
                endcase
            end
            MODE_OCTAL:
            begin
                if (is_oct)
                begin
                    acc_next = {23'd0, acc_reg[5:0], char_code[2:0]};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next >= 4'd3)
                    begin
                        if (acc_next <= cesd_pkg::OCTAL_MAX)
                        begin
                            ent = add_cp(ent, acc_next);
                        end
                        mode_next = MODE_NORMAL;
                        acc_next  = '0;
                        cnt_next  = '0;
                        inv_next  = 1'b0;
                    end
                end
                else
                begin
                    if (acc_reg <= cesd_pkg::OCTAL_MAX)
                    begin
                        ent = add_cp(ent, acc_reg);
                    end
                    acc_next = '0;
                    cnt_next = '0;
                    inv_next = 1'b0;
                    if (char_code == cesd_pkg::CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        ent       = add_cp(ent, 32'(char_code));
                    end
                end
            end
            MODE_HEX:
            begin
                if (is_hex)
                begin
                    acc_next = {acc_reg[27:0], hex_val};
                    if (cnt_reg < 4'd15)
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                else
                begin
                    if (hex_ok(acc_reg, cnt_reg))
                    begin
                        ent = add_cp(ent, acc_reg);
                    end
                    acc_next = '0;
                    cnt_next = '0;
                    inv_next = 1'b0;
                    if (char_code == cesd_pkg::CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        ent       = add_cp(ent, 32'(char_code));
                    end
                end
            end
            MODE_UNI4,
            MODE_UNI8:
            begin
                // the group always eats its full length; a bad digit voids it
                if (!inv_reg && is_hex)
                begin
                    acc_next = {acc_reg[27:0], hex_val};
                end
                else
                begin
                    inv_next = 1'b1;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_next >= need)
                begin
                    if (!inv_next)
                    begin
                        ent = add_cp(ent, acc_next);
                    end
                    mode_next = MODE_NORMAL;
                    acc_next  = '0;
                    cnt_next  = '0;
                    inv_next  = 1'b0;
                end
            end
            default:
            begin
                if (char_code == cesd_pkg::CH_BACKSLASH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    ent       = add_cp(ent, 32'(char_code));
                end
            end
        endcase

        // end of string: flush a pending octal or hex value, then start clean
        if (last)
        begin
            if (mode_next == MODE_OCTAL)
            begin
                if (acc_next <= cesd_pkg::OCTAL_MAX)
                begin
                    ent = add_cp(ent, acc_next);
                end
            end
            else if (mode_next == MODE_HEX)
            begin
                if (hex_ok(acc_next, cnt_next))
                begin
                    ent = add_cp(ent, acc_next);
                end
            end
            mode_next = MODE_NORMAL;
            acc_next  = '0;
            cnt_next  = '0;
            inv_next  = 1'b0;
        end
    end

    assign push       = accept && (ent.count != 2'd0);
    assign push_entry = ent;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            inv_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            inv_reg  <= inv_next;
        end
    end

endmodule

// File: rtl/cesd_queue.sv
// Short queue of decoded entries between front and back end.
// Uses cesd_pkg for the entry and status types.
`timescale 1ns / 1ps

module cesd_queue #(
    parameter int DEPTH = cesd_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cesd_pkg::entry_t      push_entry,
    input  logic                  pop,
    output cesd_pkg::entry_t      head,
    output cesd_pkg::queue_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cesd_pkg::entry_t slots_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slots_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/cesd_back.sv
// Back end: splits queue entries into single output words and holds
// them in the output register. Uses cesd_pkg.
`timescale 1ns / 1ps

module cesd_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cesd_pkg::entry_t            head,
    input  cesd_pkg::queue_stat_t       q_stat,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cesd_pkg::CP_W-1:0]   code_point,
    output logic                        end_of_run
);

    logic                       valid_reg, valid_next;
    logic                       half_reg, half_next;
    logic [cesd_pkg::CP_W-1:0]  data_reg, data_next;
    logic                       eor_reg, eor_next;
    logic                       load;
    logic                       pair;

    assign load = !valid_reg || out_ready;
    assign pair = (head.count == 2'd2);
    assign pop  = load && !q_stat.empty && (!pair || half_reg);

    // pick the next word from the head entry
    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        data_next  = data_reg;
        eor_next   = eor_reg;
        if (load)
        begin
            valid_next = !q_stat.empty;
            if (!q_stat.empty)
            begin
                if (pair && !half_reg)
                begin
                    data_next = head.v0;
                    eor_next  = 1'b0;
                    half_next = 1'b1;
                end
                else
                begin
                    data_next = half_reg ? head.v1 : head.v0;
                    eor_next  = 1'b1;
                    half_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        eor_reg  <= eor_next;
    end

    assign out_valid  = valid_reg;
    assign code_point = data_reg;
    assign end_of_run = eor_reg;

endmodule

// File: dv/tb_c_escape_sequence_decoder_top.sv
// Self-checking testbench for c_escape_sequence_decoder_top.
// Walks a directed stimulus table, then random escape sequences; depends on cesd_pkg and
// the RTL only. Every output word is checked against the directed table or an in-bench decoder model.
`timescale 1ns / 1ps

module tb_c_escape_sequence_decoder_top;

    typedef logic [cesd_pkg::CHAR_W-1:0]       char_t;
    typedef logic [cesd_pkg::CP_W-1:0]         cp_t;
    typedef logic [cesd_pkg::CHAR_BYTES_W-1:0] tdata_in_t;

    // decoder modes of the in-bench model
    typedef enum logic [2:0] {
        DM_TEXT = 3'd0,
        DM_ESC  = 3'd1,
        DM_OCT  = 3'd2,
        DM_HEX  = 3'd3,
        DM_U4   = 3'd4,
        DM_U8   = 3'd5
    } dec_mode_t;

    // one expected output word
    typedef struct packed {
        cp_t  code_point;
        logic end_of_run;
    } cp_word_t;

    // directed row: input word plus, where obvious, the words it must give
    typedef struct packed {
        char_t     ch;
        logic      lst;
        logic      typed;
        logic [1:0] n;
        cp_t       e0;
        cp_t       e1;
    } dir_row_t;

    localparam char_t CH_ZERO  = 21'h30;
    localparam char_t CH_SEVEN = 21'h37;
    localparam char_t CH_NINE  = 21'h39;
    localparam char_t CH_A_UP  = 21'h41;
    localparam char_t CH_F_UP  = 21'h46;
    localparam char_t CH_TOP   = 21'h10FFFF;

    localparam int DIR_ROWS    = 23;
    localparam int N_RANDOM    = 1400;
    localparam int N_TOTAL     = DIR_ROWS + N_RANDOM;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int PAUSE_AT    = 900;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    localparam char_t SIMPLE_ESC [12] = '{
        cesd_pkg::CH_A, cesd_pkg::CH_B, cesd_pkg::CH_E, cesd_pkg::CH_F,
        cesd_pkg::CH_N, cesd_pkg::CH_R, cesd_pkg::CH_T, cesd_pkg::CH_V,
        cesd_pkg::CH_BACKSLASH, cesd_pkg::CH_SQUOTE, cesd_pkg::CH_DQUOTE, cesd_pkg::CH_QMARK};

    // directed stimulus: extremes, letter escape, unknown escape, octal, hex, end cases
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{21'h41,                  1'b0, 1'b1, 2'd1, 32'h41,     32'h0},  // plain 'A'
        '{CH_TOP,                  1'b0, 1'b1, 2'd1, 32'h10FFFF, 32'h0},  // top of range
        '{21'h0,                   1'b0, 1'b1, 2'd1, 32'h0,      32'h0},  // NUL
        '{cesd_pkg::CH_BACKSLASH,  1'b0, 1'b1, 2'd0, 32'h0,      32'h0},
        '{cesd_pkg::CH_E,          1'b0, 1'b1, 2'd1, cesd_pkg::CODE_ESC, 32'h0},  // \e
        '{cesd_pkg::CH_BACKSLASH,  1'b0, 1'b1, 2'd0, 32'h0,      32'h0},
        '{21'h71,                  1'b0, 1'b1, 2'd0, 32'h0,      32'h0},  // \q dropped
        '{cesd_pkg::CH_BACKSLASH,  1'b0, 1'b0, 2'd0, 32'h0,      32'h0},
        '{21'h33,                  1'b0, 1'b0, 2'd0, 32'h0,      32'h0},  // '3'
        '{CH_SEVEN,                1'b0, 1'b0, 2'd0, 32'h0,      32'h0},
        '{CH_SEVEN,                1'b0, 1'b1, 2'd1, cesd_pkg::OCTAL_MAX, 32'h0},  // \377
        '{cesd_pkg::CH_BACKSLASH,  1'b0, 1'b0, 2'd0, 32'h0,      32'h0},
        '{21'h31,                  1'b0, 1'b0, 2'd0, 32'h0,      32'h0},  // '1'
        '{21'h5A,                  1'b0, 1'b1, 2'd2, 32'h01,     32'h5A}, // \1 ended by 'Z'
        '{cesd_pkg::CH_BACKSLASH,  1'b0, 1'b0, 2'd0, 32'h0,      32'h0},
        '{cesd_pkg::CH_X,          1'b0, 1'b0, 2'd0, 32'h0,      32'h0},
        '{21'h47,                  1'b0, 1'b1, 2'd1, 32'h47,     32'h0},  // \x, no digit, 'G'
        '{cesd_pkg::CH_BACKSLASH,  1'b0, 1'b0, 2'd0, 32'h0,      32'h0},
        '{cesd_pkg::CH_X,          1'b0, 1'b0, 2'd0, 32'h0,      32'h0},
        '{cesd_pkg::CH_F,          1'b1, 1'b1, 2'd1, 32'h0F,     32'h0},  // \xf flushed at end
        '{cesd_pkg::CH_BACKSLASH,  1'b1, 1'b1, 2'd0, 32'h0,      32'h0},  // trailing backslash
        '{cesd_pkg::CH_BACKSLASH,  1'b0, 1'b0, 2'd0, 32'h0,      32'h0},
        '{cesd_pkg::CH_U_LOW,      1'b1, 1'b1, 2'd0, 32'h0,      32'h0}   // \u cut by end
    };

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    tdata_in_t               s_tdata  = '0;   // [20:0] char_code, rest zero
    logic                    s_tlast  = 1'b0; // last
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    cp_t                     m_tdata;         // [31:0] code_point
    logic                    m_tlast;         // end_of_run

    // sideband travelling with each input word: typed expectation, if any
    dir_row_t cur_row = '0;

    // model state
    dec_mode_t dec_mode = DM_TEXT;
    cp_t       dec_acc  = '0;
    logic [3:0] dec_cnt = '0;
    logic      dec_bad  = 1'b0;
    cp_t       dec_out [2];
    int        dec_n;

    cp_word_t  cp_expected [$];
    cp_word_t  want;
    char_t     word_q [$];

    int  n_sent      = 0;
    int  n_results   = 0;
    int  n_pairs     = 0;
    int  n_errors    = 0;
    int  quiet_cycles = 0;
    bit  tx_idle_on  = 1'b1;
    bit  rx_idle_on  = 1'b1;
    bit  hold_req    = 1'b0;

    c_escape_sequence_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic bit hex_digit(input char_t c, output cp_t v);
        v = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
            v = 32'(c - CH_ZERO);
        else if (c >= cesd_pkg::CH_A && c <= cesd_pkg::CH_F)
            v = 32'(c - cesd_pkg::CH_A) + 32'd10;
        else if (c >= CH_A_UP && c <= CH_F_UP)
            v = 32'(c - CH_A_UP) + 32'd10;
        else
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit is_octal(input char_t c);
        return c >= CH_ZERO && c <= CH_SEVEN;
    endfunction

    function automatic void emit_cp(input cp_t v);
        if (dec_n < 2)
        begin
            dec_out[dec_n] = v;
            dec_n = dec_n + 1;
        end
    endfunction

    function automatic void clear_group();
        dec_acc = '0;
        dec_cnt = '0;
        dec_bad = 1'b0;
    endfunction

    function automatic void text_char(input char_t c);
        if (c == cesd_pkg::CH_BACKSLASH)
            dec_mode = DM_ESC;
        else
        begin
            dec_mode = DM_TEXT;
            emit_cp(32'(c));
        end
    endfunction

    function automatic void flush_octal();
        if (dec_acc <= cesd_pkg::OCTAL_MAX)
            emit_cp(dec_acc);
    endfunction

    // \x value is kept only outside the surrogate block and within the BMP above it
    function automatic void flush_hex();
        if (dec_cnt != 0 &&
            (dec_acc < cesd_pkg::SURR_LOW ||
             (dec_acc >= cesd_pkg::SURR_END && dec_acc <= cesd_pkg::BMP_MAX)))
            emit_cp(dec_acc);
    endfunction

    function automatic void escape_char(input char_t c);
        dec_mode = DM_TEXT;
        clear_group();
        case (c)
            cesd_pkg::CH_A:     emit_cp(cesd_pkg::CODE_BEL);
            cesd_pkg::CH_B:     emit_cp(cesd_pkg::CODE_BS);
            cesd_pkg::CH_E:     emit_cp(cesd_pkg::CODE_ESC);
            cesd_pkg::CH_F:     emit_cp(cesd_pkg::CODE_FF);
            cesd_pkg::CH_N:     emit_cp(cesd_pkg::CODE_LF);
            cesd_pkg::CH_R:     emit_cp(cesd_pkg::CODE_CR);
            cesd_pkg::CH_T:     emit_cp(cesd_pkg::CODE_HT);
            cesd_pkg::CH_V:     emit_cp(cesd_pkg::CODE_VT);
            cesd_pkg::CH_BACKSLASH, cesd_pkg::CH_SQUOTE,
            cesd_pkg::CH_DQUOTE, cesd_pkg::CH_QMARK:
                                emit_cp(32'(c));
            cesd_pkg::CH_X:     dec_mode = DM_HEX;
            cesd_pkg::CH_U_LOW: dec_mode = DM_U4;
            cesd_pkg::CH_U_UP:  dec_mode = DM_U8;
            default:
                if (is_octal(c))
                begin
                    dec_mode = DM_OCT;
                    dec_acc  = 32'(c - CH_ZERO);
                    dec_cnt  = 4'd1;
                end
        endcase
    endfunction

    // advance the model by one input word; results land in dec_out[0 .. dec_n-1]
    function automatic void decode_word(input char_t c, input logic lst);
        cp_t v;
        int  need;
        dec_n = 0;
        case (dec_mode)
            DM_ESC:
                escape_char(c);
            DM_OCT:
                if (is_octal(c))
                begin
                    dec_acc = (dec_acc * 8 + 32'(c - CH_ZERO)) & 32'h1FF;
                    dec_cnt = dec_cnt + 4'd1;
                    if (dec_cnt >= 3)
                    begin
                        flush_octal();
                        dec_mode = DM_TEXT;
                        clear_group();
                    end
                end
                else
                begin
                    flush_octal();
                    clear_group();
                    text_char(c);
                end
            DM_HEX:
                if (hex_digit(c, v))
                begin
                    dec_acc = dec_acc * 16 + v;
                    if (dec_cnt < 15)
                        dec_cnt = dec_cnt + 4'd1;
                end
                else
                begin
                    flush_hex();
                    clear_group();
                    text_char(c);
                end
            DM_U4, DM_U8:
            begin
                need = (dec_mode == DM_U4) ? 4 : 8;
                if (!dec_bad && hex_digit(c, v))
                    dec_acc = dec_acc * 16 + v;
                else
                    dec_bad = 1'b1;
                dec_cnt = dec_cnt + 4'd1;
                if (dec_cnt >= need)
                begin
                    if (!dec_bad)
                        emit_cp(dec_acc);
                    dec_mode = DM_TEXT;
                    clear_group();
                end
            end
            default:
                text_char(c);
        endcase
        // end of string: flush pending octal / hex, drop the rest
        if (lst)
        begin
            if (dec_mode == DM_OCT)
                flush_octal();
            else if (dec_mode == DM_HEX)
                flush_hex();
            dec_mode = DM_TEXT;
            clear_group();
        end
    endfunction

    // append one expected word to the scoreboard
    function automatic void queue_expected(input cp_t v, input logic eor);
        cp_word_t w;
        w.code_point = v;
        w.end_of_run = eor;
        cp_expected.insert(cp_expected.size(), w);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check output words, then predict accepted input words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_results = n_results + 1;
                if (cp_expected.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual code_point %h tlast %b",
                             $time, m_tdata, m_tlast);
                    n_errors = n_errors + 1;
                end
                else
                begin
                    want = cp_expected.pop_front();
                    if (m_tdata !== want.code_point)
                    begin
                        $display("%0t: code_point mismatch: expected %h, actual %h",
                                 $time, want.code_point, m_tdata);
                        n_errors = n_errors + 1;
                    end
                    if (m_tlast !== want.end_of_run)
                    begin
                        $display("%0t: end_of_run mismatch: expected %b, actual %b",
                                 $time, want.end_of_run, m_tlast);
                        n_errors = n_errors + 1;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                decode_word(s_tdata[cesd_pkg::CHAR_W-1:0], s_tlast);
                if (dec_n == 2)
                    n_pairs = n_pairs + 1;
                if (cur_row.typed)
                begin
                    for (int i = 0; i < int'(cur_row.n); i++)
                        queue_expected((i == 0) ? cur_row.e0 : cur_row.e1,
                                       i == int'(cur_row.n) - 1);
                end
                else
                begin
                    for (int i = 0; i < dec_n; i++)
                        queue_expected(dec_out[i], i == dec_n - 1);
                end
            end

            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // watchdog: nothing moved on either side for too long
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: timeout, no word moved for %0d cycles, %0d words outstanding",
                 $time, QUIET_LIMIT, cp_expected.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_char(input char_t c);
        word_q.insert(word_q.size(), c);
    endfunction

    function automatic char_t hex_glyph(input logic [3:0] nib);
        if (nib < 4'd10)
            return char_t'(CH_ZERO + nib);
        return char_t'(($urandom_range(0, 1) ? cesd_pkg::CH_A : CH_A_UP) + nib - 4'd10);
    endfunction

    // characters that end or spoil a digit group
    function automatic char_t odd_char();
        case ($urandom_range(0, 9))
            0:       return 21'h2F;                                  // just below '0'
            1:       return 21'h3A;                                  // just above '9'
            2:       return 21'h40;                                  // just below 'A'
            3:       return 21'h47;                                  // just above 'F'
            4:       return 21'h60;                                  // just below 'a'
            5:       return 21'h67;                                  // just above 'f'
            6:       return char_t'(21'h130 + $urandom_range(0, 9)); // digit low byte, > 0xFF
            7:       return char_t'(21'h141 + $urandom_range(0, 5)); // letter low byte, > 0xFF
            8:       return char_t'(CH_NINE - $urandom_range(0, 1)); // hex but not octal
            default: return char_t'($urandom_range(0, CH_TOP));
        endcase
    endfunction

    function automatic char_t plain_char();
        case ($urandom_range(0, 3))
            0, 1:    return char_t'($urandom_range(21'h20, 21'h7E));
            2:       return char_t'($urandom_range(0, 21'hFF));
            default: return char_t'($urandom_range(0, CH_TOP));
        endcase
    endfunction

    // one escape sequence with random content, a run of plain characters, or some noise
    task automatic build_seq();
        int          k;
        int          nd;
        logic [63:0] hv;
        k = $urandom_range(0, 99);
        word_q.delete();
        if (k < 20)
        begin
            repeat ($urandom_range(1, 4)) add_char(plain_char());
        end
        else if (k >= 95)
        begin
            repeat ($urandom_range(1, 3)) add_char(odd_char());
        end
        else
        begin
            add_char(cesd_pkg::CH_BACKSLASH);
            if (k < 35)
                add_char(SIMPLE_ESC[$urandom_range(0, 11)]);
            else if (k < 50)
            begin
                repeat ($urandom_range(1, 3)) add_char(char_t'(CH_ZERO + $urandom_range(0, 7)));
                if ($urandom_range(0, 1))
                    add_char(odd_char());
            end
            else if (k < 65)
            begin
                add_char(cesd_pkg::CH_X);
                // aim at the edges of the surrogate block now and then
                if ($urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       hv = 64'hD7FF;
                        1:       hv = 64'hD800;
                        2:       hv = 64'hDFFF;
                        3:       hv = 64'hE000;
                        4:       hv = 64'hFFFF;
                        default: hv = 64'h10000;
                    endcase
                    nd = $urandom_range(4, 6);
                end
                else
                begin
                    hv = {$urandom, $urandom};
                    nd = $urandom_range(0, 10);
                end
                for (int i = nd - 1; i >= 0; i--)
                    add_char(hex_glyph(hv[4*i +: 4]));
                if ($urandom_range(0, 1))
                    add_char(odd_char());
            end
            else if (k < 90)
            begin
                nd = (k < 80) ? 4 : 8;
                add_char((k < 80) ? cesd_pkg::CH_U_LOW : cesd_pkg::CH_U_UP);
                hv = ($urandom_range(0, 7) == 0) ? 64'hFFFF_FFFF : {32'h0, $urandom};
                for (int i = nd - 1; i >= 0; i--)
                    add_char(hex_glyph(hv[4*i +: 4]));
                // spoil one digit of the group
                if ($urandom_range(0, 4) == 0)
                    word_q[1 + $urandom_range(1, nd)] = odd_char();
            end
            else
                add_char(char_t'($urandom_range(21'h20, 21'h7E)));
        end
    endtask

    // offer one word and wait for it to be taken
    task automatic send_word(input char_t c, input logic lst, input dir_row_t row);
        s_tvalid <= 1'b1;
        s_tdata  <= tdata_in_t'(c);
        s_tlast  <= lst;
        cur_row  <= row;
        do
            @(posedge clk);
        while (!s_tready);
        n_sent = n_sent + 1;

        // idling windows: off for a stretch mid-run and for the tail
        tx_idle_on = !((n_sent >= DIR_ROWS + 200 && n_sent < DIR_ROWS + 400) ||
                       n_sent >= N_TOTAL - 200);
        rx_idle_on = tx_idle_on;
        if (n_sent == HOLD_AT)
            hold_req = 1'b1;

        if (n_sent == PAUSE_AT)
        begin
            // sender waits until the block has drained
            s_tvalid <= 1'b0;
            @(negedge clk);
            while (cp_expected.size() != 0)
                @(posedge clk);
            repeat (DRAIN_WAIT) @(posedge clk);
        end
        else if (tx_idle_on && !hold_req && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= tdata_in_t'($urandom_range(0, CH_TOP));
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_word(DIR_TAB[r].ch, DIR_TAB[r].lst, DIR_TAB[r]);

        // random strings; a string may end after a sequence, or mid-sequence now and then
        while (n_sent < N_TOTAL)
        begin
            build_seq();
            for (int i = 0; i < word_q.size(); i++)
                send_word(word_q[i],
                          (i == word_q.size() - 1 && $urandom_range(0, 2) == 0) ||
                          $urandom_range(0, 49) == 0,
                          '0);
        end
        s_tvalid <= 1'b0;

        @(negedge clk);
        while (cp_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d words (%0d directed), checked %0d decoded words, %0d double results",
                 n_sent, DIR_ROWS, n_results, n_pairs);
        $display("Covered letter, octal, \\x, \\u and \\U escapes, stalls and a drain pause");
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
